/* sv/unicode_escape_to_utf8_core_assert.svh */
// ----------------------------------------------------------------------------
// unicode_escape_to_utf8_core assertion macros
// Shared concurrent assertion forms for the escape-to-UTF-8 core.
// ----------------------------------------------------------------------------
`ifndef UNICODE_ESCAPE_TO_UTF8_CORE_ASSERT_SVH
`define UNICODE_ESCAPE_TO_UTF8_CORE_ASSERT_SVH

// same-cycle implication
`define UE2U_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ue2u assertion failed");

// next-cycle implication
`define UE2U_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ue2u assertion failed");

`endif

/* sv/ue2u_pkg.sv */
// ----------------------------------------------------------------------------
// ue2u_pkg
// Types and constants shared by the escape-to-UTF-8 core.
// ----------------------------------------------------------------------------
`default_nettype none

package ue2u_pkg;

    localparam int MAX_RES = 6;

    typedef logic [7:0] t_byte;

    localparam t_byte CH_BSLASH = 8'h5C;
    localparam t_byte CH_U      = 8'h75;

    // one queued job: the output bytes caused by one input byte
    typedef struct packed {
        logic [2:0]               cnt;
        t_byte [MAX_RES-1:0]      bytes;
    } t_job;

endpackage

`default_nettype wire

/* sv/ue2u_front.sv */
// ----------------------------------------------------------------------------
// ue2u_front
// Escape parser: accepts input bytes and builds the output byte list per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ue2u_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire ue2u_pkg::t_byte i_byte,
    input  wire logic            i_last,
    input  wire logic            i_full,
    output logic                 o_push,
    output ue2u_pkg::t_job       o_job
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_BS   = 6'b000010,
        ST_U    = 6'b000100,
        ST_D1   = 6'b001000,
        ST_D2   = 6'b010000,
        ST_D3   = 6'b100000
    } t_stage;

    function automatic logic [2:0] pend_len(t_stage s);
        logic [2:0] len;
        unique case (s)
            ST_IDLE: len = 3'd0;
            ST_BS:   len = 3'd1;
            ST_U:    len = 3'd2;
            ST_D1:   len = 3'd3;
            ST_D2:   len = 3'd4;
            ST_D3:   len = 3'd5;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    t_stage                    r_st, n_st;
    logic [11:0]               r_acc, n_acc;
    ue2u_pkg::t_byte [2:0]     r_dig, n_dig;

    logic                      is_hex, is_bs, brk, fresh;
    logic [3:0]                nib;
    logic [15:0]               cp;
    logic [2:0]                mcnt, hl, tl, jj, off_m, off_t;
    ue2u_pkg::t_byte           pend [8];
    ue2u_pkg::t_byte           mid  [8];
    ue2u_pkg::t_byte           tail [8];
    logic                      accept;

    always_comb begin
        is_hex = 1'b1;
        nib    = i_byte[3:0];
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            nib = i_byte[3:0];
        end else if ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46)) begin
            nib = i_byte[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    always_comb begin
        is_bs = (i_byte == ue2u_pkg::CH_BSLASH);
        n_st  = r_st;
        n_acc = r_acc;
        n_dig = r_dig;
        brk   = 1'b0;
        fresh = 1'b0;
        mcnt  = 3'd0;
        cp    = {r_acc, nib};
        for (int k = 0; k < 8; k++) begin
            mid[k] = '0;
        end
        unique case (r_st)
            ST_IDLE: fresh = 1'b1;
            ST_BS: begin
                if (i_byte == ue2u_pkg::CH_U) begin
                    n_st = ST_U;
                end else begin
                    brk   = 1'b1;
                    fresh = 1'b1;
                end
            end
            ST_U: begin
                if (is_hex) begin
                    n_dig[0] = i_byte;
                    n_acc    = {8'd0, nib};
                    n_st     = ST_D1;
                end else begin
                    brk   = 1'b1;
                    fresh = 1'b1;
                end
            end
            ST_D1: begin
                if (is_hex) begin
                    n_dig[1] = i_byte;
                    n_acc    = {r_acc[7:0], nib};
                    n_st     = ST_D2;
                end else begin
                    brk   = 1'b1;
                    fresh = 1'b1;
                end
            end
            ST_D2: begin
                if (is_hex) begin
                    n_dig[2] = i_byte;
                    n_acc    = {r_acc[7:0], nib};
                    n_st     = ST_D3;
                end else begin
                    brk   = 1'b1;
                    fresh = 1'b1;
                end
            end
            ST_D3: begin
                if (is_hex) begin
                    n_st = ST_IDLE;
                    if (cp <= 16'h007F) begin
                        mid[0] = cp[7:0];
                        mcnt   = 3'd1;
                    end else if (cp <= 16'h07FF) begin
                        mid[0] = {3'b110, cp[10:6]};
                        mid[1] = {2'b10, cp[5:0]};
                        mcnt   = 3'd2;
                    end else begin
                        mid[0] = {4'b1110, cp[15:12]};
                        mid[1] = {2'b10, cp[11:6]};
                        mid[2] = {2'b10, cp[5:0]};
                        mcnt   = 3'd3;
                    end
                end else begin
                    brk   = 1'b1;
                    fresh = 1'b1;
                end
            end
            default: fresh = 1'b1;
        endcase
        if (fresh) begin
            if (is_bs) begin
                n_st = ST_BS;
            end else begin
                n_st   = ST_IDLE;
                mid[0] = i_byte;
                mcnt   = 3'd1;
            end
        end

        pend[0] = ue2u_pkg::CH_BSLASH;
        pend[1] = ue2u_pkg::CH_U;
        pend[2] = r_dig[0];
        pend[3] = r_dig[1];
        pend[4] = r_dig[2];
        pend[5] = '0;
        pend[6] = '0;
        pend[7] = '0;
        tail[0] = ue2u_pkg::CH_BSLASH;
        tail[1] = ue2u_pkg::CH_U;
        tail[2] = n_dig[0];
        tail[3] = n_dig[1];
        tail[4] = n_dig[2];
        tail[5] = '0;
        tail[6] = '0;
        tail[7] = '0;

        hl = brk ? pend_len(r_st) : 3'd0;
        tl = i_last ? pend_len(n_st) : 3'd0;
        o_job.cnt = hl + mcnt + tl;
        for (int j = 0; j < ue2u_pkg::MAX_RES; j++) begin
            jj    = 3'(j);
            off_m = jj - hl;
            off_t = jj - hl - mcnt;
            if (jj < hl) begin
                o_job.bytes[j] = pend[jj];
            end else if (off_m < mcnt) begin
                o_job.bytes[j] = mid[off_m];
            end else begin
                o_job.bytes[j] = tail[off_t];
            end
        end
    end

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (o_job.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else if (accept) begin
            r_st <= i_last ? ST_IDLE : n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc <= n_acc;
            r_dig <= n_dig;
        end
    end

endmodule

`default_nettype wire

/* sv/ue2u_fifo.sv */
// ----------------------------------------------------------------------------
// ue2u_fifo
// Short job queue between the parser and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module ue2u_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ue2u_pkg::t_job i_data,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output ue2u_pkg::t_job      o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ue2u_pkg::t_job  r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* sv/ue2u_back.sv */
// ----------------------------------------------------------------------------
// ue2u_back
// Byte serializer: walks the head job and drives the registered output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "unicode_escape_to_utf8_core_assert.svh"

module ue2u_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire ue2u_pkg::t_job i_head,
    output logic                o_pop,
    output logic                o_tvalid,
    input  wire logic           i_tready,
    output ue2u_pkg::t_byte     o_tdata,
    output logic                o_tlast
);

    logic            r_ovalid;
    ue2u_pkg::t_byte r_obyte;
    logic            r_olast;
    logic [2:0]      r_idx;
    logic            ld, is_last;

    assign ld      = !i_empty && (!r_ovalid || i_tready);
    assign is_last = (r_idx == i_head.cnt - 3'd1);
    assign o_pop   = ld && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (ld) begin
                r_ovalid <= 1'b1;
                r_idx    <= is_last ? 3'd0 : r_idx + 3'd1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_obyte <= i_head.bytes[r_idx];
            r_olast <= is_last;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_obyte;
    assign o_tlast  = r_olast;

    `UE2U_ASSERT_IMP(a_idx_in_job, i_clk, i_rst_n, !i_empty, r_idx < i_head.cnt)
    `UE2U_ASSERT_IMP(a_idx_at_start, i_clk, i_rst_n, i_empty, r_idx == 3'd0)
    `UE2U_ASSERT_NXT(a_pop_marks_last, i_clk, i_rst_n, o_pop, o_tvalid && o_tlast)

endmodule

`default_nettype wire

/* sv/unicode_escape_to_utf8_core.sv */
// ----------------------------------------------------------------------------
// unicode_escape_to_utf8_core
// Rewrites backslash-u hex4 escapes in a byte stream into UTF-8.
// ----------------------------------------------------------------------------
// Input stream s_axis: one text byte per transfer in tdata, tlast set on the
// final byte of the text (pending escape bytes are then flushed literally).
// Output stream m_axis: converted bytes in tdata; tlast is set on the last
// byte that a given input byte produced. An input byte produces zero to six
// output bytes (none while an escape is still being collected).
// Each input byte's output bytes pass through the job queue and then the
// output register. Output runs at one byte per cycle while m_axis_tready is
// high; the output register is the limit. A QUEUE_DEPTH-entry job queue
// lets the parser keep taking bytes while the output drains a longer run.
// Reset clears the parser state, empties the queue and clears the output valid.
// When m_axis_tready is low the output holds, the queue fills and then
// s_axis_tready drops until space frees up; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module unicode_escape_to_utf8_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  wire logic       s_axis_tlast,   // end_of_text
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast    // run_last
);

    logic           push, pop, full, empty;
    ue2u_pkg::t_job job, head;

    ue2u_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job)
    );

    ue2u_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    ue2u_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
